// ===== sv/tdfs_pkg.sv =====
// Shared types and constants of the timer divider factor search block.
package tdfs_pkg;

  // Result status codes.
  typedef logic [1:0] status_t;

  localparam status_t ST_OK        = 2'd0;
  localparam status_t ST_BAD_FREQ  = 2'd1;
  localparam status_t ST_NO_FACTOR = 2'd2;

  // Reset value of the system clock register.
  localparam logic [31:0] CLOCK_HZ_RESET = 32'd120000000;

  // Widths of the shared divider's dividend and divisor, and its step count.
  localparam int NUM_W     = 34;
  localparam int DEN_W     = 33;
  localparam int DIV_STEPS = 34;

endpackage

// ===== sv/timer_divider_factor_search.sv =====
// Top level of the timer divider factor search: rounding divider and divisor search.
//
// Usage:
//   A transaction is accepted at a rising edge with start high and busy low. It carries
//   the wanted timer rate in_wanted_hz and the timer selector in_timer_unit.
//   The block forms the target count clock_hz / wanted_hz, rounded to nearest with ties
//   away from zero, then tries divisors in increasing order, starting at the smallest
//   one that keeps the quotient within the counter range.
//   One restoring divider (one quotient bit per cycle) does both the target division and
//   every trial division, under a small sequencer.
//   A zero rate gives its result in the cycle after acceptance. Otherwise the target
//   division runs first, then each divisor tried passes a bound check, the divide steps and
//   an evaluation; the search ends with a hit at an evaluation or a miss at a bound check.
//   For a nonzero rate, busy is high from acceptance until the result is shown, so one item
//   is in work at a time. The result appears for exactly one cycle with out_valid high, in
//   the cycle busy falls (or in the cycle after a zero-rate acceptance); the receiver cannot stall.
//   A rising edge with cfg_wr_en high writes cfg_wr_data into the clock register; the user
//   must write it only while the block is idle, as the block itself does not enforce this.
//   Synchronous reset clears the sequencer and the strobe and sets the clock register
//   to 120 MHz.
module timer_divider_factor_search #(
  parameter int COUNTER_BITS = 16
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  logic [31:0]       in_wanted_hz,
  input  logic [2:0]        in_timer_unit,
  output logic              out_valid,
  output tdfs_pkg::status_t out_status,
  output logic [15:0]       out_prescale,
  output logic [15:0]       out_period,
  output logic [2:0]        out_unit_out,
  input  logic              cfg_wr_en,
  input  logic [31:0]       cfg_wr_data
);
  import tdfs_pkg::*;

  // Sequencer states.
  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_TGT  = 3'd1;
  localparam logic [2:0] S_SEED = 3'd2;
  localparam logic [2:0] S_CHK  = 3'd3;
  localparam logic [2:0] S_TRY  = 3'd4;
  localparam logic [2:0] S_EVAL = 3'd5;

  // Quotient limit, divisor limit and rounding-up addend of the starting divisor.
  localparam logic [NUM_W-1:0] QUOT_LIMIT = {{(NUM_W-1){1'b0}}, 1'b1} << COUNTER_BITS;
  localparam logic [NUM_W-1:0] DIV_LIMIT  = QUOT_LIMIT - {{(NUM_W-1){1'b0}}, 1'b1};

  localparam int CNT_W = $clog2(DIV_STEPS);
  localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(DIV_STEPS - 1);

  logic [2:0]       state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic [31:0]      clock_hz_r;

  logic [NUM_W-1:0] quo_r, quo_nxt;
  logic [DEN_W-1:0] rem_r, rem_nxt;
  logic [DEN_W-1:0] den_r, den_nxt;
  logic [31:0]      tgt_r, tgt_nxt;
  logic [DEN_W-1:0] d_r, d_nxt;
  logic [2:0]       unit_r, unit_nxt;
  status_t          status_r, status_nxt;
  logic [15:0]      pre_r, pre_nxt;
  logic [15:0]      per_r, per_nxt;

  // Shared divider step.
  logic [NUM_W-1:0] trial;
  logic             ge;
  logic [NUM_W-1:0] diff;
  logic [DEN_W-1:0] step_rem;
  logic [NUM_W-1:0] step_quo;

  // Starting divisor, and quotient and divisor minus one.
  logic [NUM_W-1:0] seed_sum;
  logic [NUM_W-1:0] seed_d;
  logic [NUM_W-1:0] quo_m1;
  logic [DEN_W-1:0] d_m1;

  logic accept;

  assign accept = start && (state_r == S_IDLE);

  // One restoring division step: shift in the next dividend bit and try a subtract.
  always_comb begin
    trial    = {rem_r, quo_r[NUM_W-1]};
    ge       = trial >= {1'b0, den_r};
    diff     = trial - {1'b0, den_r};
    step_rem = ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
    step_quo = {quo_r[NUM_W-2:0], ge};
  end

  // Starting divisor is the target divided by the quotient limit, rounded up, at least one.
  always_comb begin
    seed_sum = {2'b00, quo_r[31:0]} + DIV_LIMIT;
    seed_d   = seed_sum >> COUNTER_BITS;
    quo_m1   = quo_r - {{(NUM_W-1){1'b0}}, 1'b1};
    d_m1     = d_r - {{(DEN_W-1){1'b0}}, 1'b1};
  end

  // Sequencer and datapath next values.
  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    out_valid_nxt = 1'b0;
    quo_nxt       = quo_r;
    rem_nxt       = rem_r;
    den_nxt       = den_r;
    tgt_nxt       = tgt_r;
    d_nxt         = d_r;
    unit_nxt      = unit_r;
    status_nxt    = status_r;
    pre_nxt       = pre_r;
    per_nxt       = per_r;

    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          unit_nxt = in_timer_unit;
          if (in_wanted_hz == 32'd0) begin
            status_nxt    = ST_BAD_FREQ;
            pre_nxt       = 16'd0;
            per_nxt       = 16'd0;
            out_valid_nxt = 1'b1;
          end else begin
            // Target = (2*clock + rate) / (2*rate).
            quo_nxt   = {1'b0, clock_hz_r, 1'b0} + {2'b00, in_wanted_hz};
            den_nxt   = {in_wanted_hz, 1'b0};
            rem_nxt   = '0;
            cnt_nxt   = '0;
            state_nxt = S_TGT;
          end
        end
      end
      S_TGT, S_TRY: begin
        quo_nxt = step_quo;
        rem_nxt = step_rem;
        cnt_nxt = cnt_r + CNT_W'(1);
        if (cnt_r == LAST_STEP) begin
          state_nxt = (state_r == S_TGT) ? S_SEED : S_EVAL;
        end
      end
      S_SEED: begin
        tgt_nxt = quo_r[31:0];
        if (seed_d == '0) begin
          d_nxt = {{(DEN_W-1){1'b0}}, 1'b1};
        end else begin
          d_nxt = seed_d[DEN_W-1:0];
        end
        state_nxt = S_CHK;
      end
      S_CHK: begin
        if (({1'b0, d_r} > DIV_LIMIT) || (d_r > {1'b0, tgt_r})) begin
          status_nxt    = ST_NO_FACTOR;
          pre_nxt       = 16'd0;
          per_nxt       = 16'd0;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end else begin
          quo_nxt   = {2'b00, tgt_r};
          den_nxt   = d_r;
          rem_nxt   = '0;
          cnt_nxt   = '0;
          state_nxt = S_TRY;
        end
      end
      S_EVAL: begin
        if ((rem_r == '0) && (quo_r <= QUOT_LIMIT)) begin
          status_nxt    = ST_OK;
          pre_nxt       = d_m1[15:0];
          per_nxt       = quo_m1[15:0];
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end else begin
          d_nxt     = d_r + {{(DEN_W-1){1'b0}}, 1'b1};
          state_nxt = S_CHK;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control registers and the clock register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
      clock_hz_r  <= CLOCK_HZ_RESET;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_wr_en) begin
        clock_hz_r <= cfg_wr_data;
      end
    end
  end

  // Datapath and result registers.
  always_ff @(posedge clk) begin
    quo_r    <= quo_nxt;
    rem_r    <= rem_nxt;
    den_r    <= den_nxt;
    tgt_r    <= tgt_nxt;
    d_r      <= d_nxt;
    unit_r   <= unit_nxt;
    status_r <= status_nxt;
    pre_r    <= pre_nxt;
    per_r    <= per_nxt;
  end

  assign busy         = (state_r != S_IDLE);
  assign out_valid    = out_valid_r;
  assign out_status   = status_r;
  assign out_prescale = pre_r;
  assign out_period   = per_r;
  assign out_unit_out = unit_r;

endmodule

// ===== sv/tdfs_checker.sv =====
// Port-level assertions for the timer divider factor search, bound to the top level.
module tdfs_checker (
  input logic              clk,
  input logic              rst_n,
  input logic              start,
  input logic              busy,
  input logic [31:0]       in_wanted_hz,
  input logic              out_valid,
  input tdfs_pkg::status_t out_status,
  input logic [15:0]       out_prescale,
  input logic [15:0]       out_period
);
  import tdfs_pkg::*;

  // A zero rate is rejected in the very next cycle.
  a_bad_freq: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && (in_wanted_hz == 32'd0)) |=> (out_valid && (out_status == ST_BAD_FREQ)))
    else $error("zero rate transaction not rejected in the next cycle");

  // An accepted transaction either keeps the block busy or has its result shown.
  a_accept_progress: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> (busy || out_valid))
    else $error("accepted transaction neither in work nor answered");

  // The end of a search always shows its result.
  a_done_result: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(busy) |-> out_valid)
    else $error("search ended without a result strobe");

  // Failed requests carry zero settings.
  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_status != ST_OK)) |-> ((out_prescale == 16'd0) && (out_period == 16'd0)))
    else $error("failed result carries nonzero settings");

endmodule

bind timer_divider_factor_search tdfs_checker u_tdfs_checker (.*);

// ===== tb/timer_divider_factor_search_checker.sv =====
// Checker for the timer divider factor search: predicts each result and compares it.
module timer_divider_factor_search_checker (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic              busy,
  input  logic [31:0]       in_wanted_hz,
  input  logic [2:0]        in_timer_unit,
  input  logic              out_valid,
  input  tdfs_pkg::status_t out_status,
  input  logic [15:0]       out_prescale,
  input  logic [15:0]       out_period,
  input  logic [2:0]        out_unit_out,
  input  logic              cfg_wr_en,
  input  logic [31:0]       cfg_wr_data,
  output int                mismatches,
  output int                pending,
  output int                checked,
  output int                found_count,
  output int                bad_rate_count,
  output int                no_factor_count
);
  timeunit 1ns;
  timeprecision 1ps;
  import tdfs_pkg::*;

  localparam int          COUNTER_BITS = 16;
  localparam logic [63:0] QUOT_MAX     = 64'd1 << COUNTER_BITS;
  localparam logic [63:0] DIV_MAX      = QUOT_MAX - 64'd1;

  typedef struct packed {
    status_t     status;
    logic [15:0] prescale;
    logic [15:0] period;
    logic [2:0]  unit;
  } timer_setting_t;

  // One accepted request together with the setting it should produce.
  typedef struct {
    timer_setting_t setting;
    logic [31:0]    rate;
    logic [31:0]    clock;
  } timer_request_t;

  timer_request_t expected_settings[$];
  logic [31:0]    clock_hz_copy;

  // Rounds the target count, then walks the divisors upward from the smallest one
  // that keeps the quotient within the counter range.
  function automatic timer_setting_t solve_timer_setting(logic [31:0] clock,
                                                          logic [31:0] rate,
                                                          logic [2:0]  unit);
    logic [63:0]    target;
    logic [63:0]    div;
    logic [63:0]    quo;
    timer_setting_t s;
    s.status   = ST_NO_FACTOR;
    s.prescale = '0;
    s.period   = '0;
    s.unit     = unit;
    if (rate == '0) begin
      s.status = ST_BAD_FREQ;
      return s;
    end
    target = ({32'd0, clock} * 2 + rate) / ({32'd0, rate} * 2);
    div = (target + QUOT_MAX - 64'd1) / QUOT_MAX;
    if (div == '0) begin
      div = 64'd1;
    end
    while (div <= DIV_MAX && div <= target) begin
      quo = target / div;
      if (target % div == '0 && quo <= QUOT_MAX) begin
        s.status   = ST_OK;
        s.prescale = 16'(div - 64'd1);
        s.period   = 16'(quo - 64'd1);
        return s;
      end
      div++;
    end
    return s;
  endfunction

  // Prints one line per wrong field or unexpected result and counts it.
  task automatic report_mismatch(input string msg);
    $display("MISMATCH at %0t ns: %s", $time, msg);
    mismatches++;
  endtask

  // The result is checked first, then a new transaction is queued under the clock value
  // in force before this edge, and a clock write at this edge takes effect last.
  always @(posedge clk) begin : monitor
    timer_request_t want;
    timer_setting_t got;
    if (!rst_n) begin
      clock_hz_copy = CLOCK_HZ_RESET;
      expected_settings.delete();
      mismatches      = 0;
      checked         = 0;
      found_count     = 0;
      bad_rate_count  = 0;
      no_factor_count = 0;
    end else begin
      if (out_valid) begin
        got = '{status: out_status, prescale: out_prescale, period: out_period,
                unit: out_unit_out};
        if (expected_settings.size() == 0) begin
          report_mismatch($sformatf("result with nothing outstanding: status %0d", got.status));
        end else begin
          want = expected_settings.pop_front();
          checked++;
          case (want.setting.status)
            ST_OK:       found_count++;
            ST_BAD_FREQ: bad_rate_count++;
            default:     no_factor_count++;
          endcase
          if (got.status !== want.setting.status)
            report_mismatch($sformatf("clock %0d rate %0d: status %0d, expected %0d",
                                      want.clock, want.rate, got.status, want.setting.status));
          if (got.prescale !== want.setting.prescale)
            report_mismatch($sformatf("clock %0d rate %0d: prescale %0d, expected %0d",
                                      want.clock, want.rate, got.prescale,
                                      want.setting.prescale));
          if (got.period !== want.setting.period)
            report_mismatch($sformatf("clock %0d rate %0d: period %0d, expected %0d",
                                      want.clock, want.rate, got.period, want.setting.period));
          if (got.unit !== want.setting.unit)
            report_mismatch($sformatf("clock %0d rate %0d: unit %0d, expected %0d",
                                      want.clock, want.rate, got.unit, want.setting.unit));
        end
      end
      if (start && !busy) begin
        want.rate    = in_wanted_hz;
        want.clock   = clock_hz_copy;
        want.setting = solve_timer_setting(clock_hz_copy, in_wanted_hz, in_timer_unit);
        expected_settings.push_back(want);
      end
      if (cfg_wr_en) begin
        clock_hz_copy = cfg_wr_data;
      end
    end
    pending = expected_settings.size();
  end

endmodule

// ===== tb/timer_divider_factor_search_tb.sv =====
// Testbench top for the timer divider factor search: clock, reset, stimulus and verdict.
module timer_divider_factor_search_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import tdfs_pkg::*;

  localparam int NUM_SETTINGS       = 10;
  localparam int RANDOM_PER_SETTING = 103;
  // Requests whose divisor walk is longer than this are redrawn to bound run time.
  localparam int unsigned TRIAL_BUDGET = 100;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        start;
  logic        busy;
  logic [31:0] in_wanted_hz;
  logic [2:0]  in_timer_unit;
  logic        out_valid;
  status_t     out_status;
  logic [15:0] out_prescale;
  logic [15:0] out_period;
  logic [2:0]  out_unit_out;
  logic        cfg_wr_en;
  logic [31:0] cfg_wr_data;

  int          mismatches;
  int          pending;
  int          checked;
  int          found_count;
  int          bad_rate_count;
  int          no_factor_count;
  int          sent;
  bit          idling_on;
  logic [31:0] cur_clock;
  logic [31:0] clock_plan[NUM_SETTINGS];

  always #6 clk = ~clk;

  timer_divider_factor_search dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .busy          (busy),
    .in_wanted_hz  (in_wanted_hz),
    .in_timer_unit (in_timer_unit),
    .out_valid     (out_valid),
    .out_status    (out_status),
    .out_prescale  (out_prescale),
    .out_period    (out_period),
    .out_unit_out  (out_unit_out),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_wr_data   (cfg_wr_data)
  );

  timer_divider_factor_search_checker u_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_wanted_hz    (in_wanted_hz),
    .in_timer_unit   (in_timer_unit),
    .out_valid       (out_valid),
    .out_status      (out_status),
    .out_prescale    (out_prescale),
    .out_period      (out_period),
    .out_unit_out    (out_unit_out),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_wr_data     (cfg_wr_data),
    .mismatches      (mismatches),
    .pending         (pending),
    .checked         (checked),
    .found_count     (found_count),
    .bad_rate_count  (bad_rate_count),
    .no_factor_count (no_factor_count)
  );

  // Number of divisors the search will try for this request, cut off past the budget.
  function automatic int unsigned trial_count(logic [31:0] clock, logic [31:0] rate);
    logic [63:0] target;
    logic [63:0] div;
    int unsigned n;
    n = 0;
    if (rate == '0) begin
      return 0;
    end
    target = ({32'd0, clock} * 2 + rate) / ({32'd0, rate} * 2);
    div = (target + 64'd65535) / 64'd65536;
    if (div == '0) begin
      div = 64'd1;
    end
    while (div <= 64'd65535 && div <= target && n <= TRIAL_BUDGET) begin
      n++;
      if (target % div == '0 && target / div <= 64'd65536) begin
        return n;
      end
      div++;
    end
    return n;
  endfunction

  // Mixes full-range rates, rates aimed at small targets and at large ones, and edge values.
  function automatic logic [31:0] pick_rate(logic [31:0] clock);
    logic [63:0] w;
    int unsigned tgt;
    case ($urandom_range(0, 9))
      0, 1, 2: w = $urandom;
      3, 4, 5, 6: begin
        tgt = $urandom_range(1, 65536);
        w   = clock / tgt + $urandom_range(0, 1);
      end
      7, 8: w = $urandom_range(1, 4096);
      default: begin
        case ($urandom_range(0, 3))
          0:       w = '0;
          1:       w = 64'd1;
          2:       w = 64'hFFFF_FFFF;
          default: w = {32'd0, clock} << 1;
        endcase
      end
    endcase
    if (w > 64'hFFFF_FFFF) begin
      w = 64'hFFFF_FFFF;
    end
    return w[31:0];
  endfunction

  // Presents one transaction and waits until the block takes it; start stays high.
  task automatic send_request(input logic [31:0] rate, input logic [2:0] unit);
    @(negedge clk);
    start         <= 1'b1;
    in_wanted_hz  <= rate;
    in_timer_unit <= unit;
    do @(posedge clk); while (busy);
    sent++;
  endtask

  task automatic hold_off(input int cycles);
    repeat (cycles) begin
      @(negedge clk);
      start <= 1'b0;
    end
  endtask

  // Lets every outstanding result come back before the clock register is touched.
  task automatic drain();
    @(negedge clk);
    start <= 1'b0;
    while (pending != 0 || busy) @(negedge clk);
  endtask

  task automatic set_clock(input logic [31:0] value);
    @(negedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(negedge clk);
    cfg_wr_en   <= 1'b0;
    cur_clock = value;
  endtask

  // Hand-picked requests for clock settings before the random one: zero rate,
  // rounding ties, the largest period and prescale, and unfactorable targets.
  task automatic send_directed(input int setting);
    case (setting)
      0: begin
        send_request(32'd0, 3'd7);
        send_request(32'd1, 3'd0);
        send_request(32'hFFFF_FFFF, 3'd5);
        send_request(32'd240_000_000, 3'd1);
        send_request(32'd80_000_000, 3'd2);
        send_request(32'd48_000_000, 3'd3);
        send_request(32'd1832, 3'd4);
      end
      1: begin
        send_request(32'd1000, 3'd6);
        send_request(32'd1, 3'd1);
      end
      2: begin
        send_request(32'd1, 3'd2);
        send_request(32'd2, 3'd3);
        send_request(32'd3, 3'd4);
      end
      3: begin
        send_request(32'd5, 3'd0);
        send_request(32'd0, 3'd1);
      end
      4: begin
        send_request(32'd1, 3'd7);
        send_request(32'd2, 3'd6);
      end
      5: send_request(32'd1, 3'd3);
      6: send_request(32'd1, 3'd2);
      default: ;
    endcase
  endtask

  // Main sequence: reset, then one phase per clock setting.
  initial begin : stimulus
    logic [31:0] rate;
    rst_n         = 1'b0;
    start         = 1'b0;
    in_wanted_hz  = '0;
    in_timer_unit = '0;
    cfg_wr_en     = 1'b0;
    cfg_wr_data   = '0;
    sent          = 0;
    idling_on     = 1'b1;
    cur_clock     = CLOCK_HZ_RESET;
    clock_plan    = '{CLOCK_HZ_RESET, 32'd65_536_000, 32'd1, 32'd0, 32'hFFFF_FFFF,
                      32'd4_294_901_760, 32'd4_294_967_291, $urandom, 32'd16_000_000,
                      CLOCK_HZ_RESET};
    repeat (6) @(negedge clk);
    rst_n <= 1'b1;

    for (int setting = 0; setting < NUM_SETTINGS; setting++) begin
      if (setting != 0) begin
        drain();
        set_clock(clock_plan[setting]);
      end
      send_directed(setting);
      idling_on = (setting != NUM_SETTINGS - 1);
      repeat (RANDOM_PER_SETTING) begin
        if (idling_on && $urandom_range(0, 2) == 0) begin
          hold_off($urandom_range(1, 5));
        end
        do rate = pick_rate(cur_clock); while (trial_count(cur_clock, rate) > TRIAL_BUDGET);
        send_request(rate, 3'($urandom_range(0, 7)));
      end
    end

    drain();
    repeat (100) @(negedge clk);

    $display("Ran %0d transactions across %0d clock settings, from zero to full scale.",
             sent, NUM_SETTINGS);
    $display("Checked %0d results: %0d factorized, %0d invalid rate, %0d not factorable.",
             checked, found_count, bad_rate_count, no_factor_count);
    if (mismatches == 0 && pending == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  // Watchdog against a hung handshake.
  initial begin : watchdog
    #150_000_000;
    $display("Timed out with %0d results outstanding.", pending);
    $display("end of test: mismatches");
    $finish;
  end

endmodule
